// ===== src/stalta_pkg.sv =====
package stalta_pkg;

  localparam int SampleW   = 24;
  localparam int WinW      = 11;
  localparam int MaxWindow = 1024;
  localparam int HistAw    = $clog2(MaxWindow);
  localparam int PosW      = 16;
  localparam int MaxTrace  = 65535;
  localparam int SqW       = 2 * SampleW - 1;
  localparam int SumW      = SqW + HistAw;
  localparam int HalfW     = (SumW + 1) / 2;
  localparam int ProdW     = 2 * HalfW;
  localparam int AccW      = 2 * SumW;
  localparam int PickW     = 17;
  localparam int OutW      = PickW + 2;
  localparam int OutBytesW = ((OutW + 7) / 8) * 8;
  localparam int InBytesW  = ((SampleW + 7) / 8) * 8;
  localparam int CntW      = 4;
  localparam int NumPart   = 8;

  localparam int WinShortDef = 10;
  localparam int WinLongDef  = 30;

  // register indexes (word address bit)
  localparam logic RegShort = 1'b0;
  localparam logic RegLong  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SQ    = 8'b0000_0010,
    S_SUB_S = 8'b0000_0100,
    S_SUB_L = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

endpackage

// ===== src/stalta_ram.sv =====
module stalta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sta_lta_first_arrival_picker.sv =====
// Output: a result is registered in the final step and shown as the sequencer returns to idle.
// Samples: one at a time; a new sample is taken only after the last has finished, a ratio compare
//   adding 8 partial products through the one 29x29 multiplier plus accumulate and compare,
//   and a trace past the maximum length skipping straight from the square step to the final one.
// Reset (rst_ni low, asynchronous): windows back to 10 and 30, trace state cleared,
//   no result pending. The square history needs no clearing.
module sta_lta_first_arrival_picker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input samples
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [stalta_pkg::InBytesW-1:0]      s_axis_tdata,   // [23:0] sample
  input  logic                                 s_axis_tlast,   // last_sample
  // pick results
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [stalta_pkg::OutBytesW-1:0]     m_axis_tdata,   // [16:0] pick_index,
                                                               // [17] no_pick, [18] too_long
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import stalta_pkg::*;

  // ---------------------------------------------------------------------------
  // Window registers; out-of-range values are clamped where used
  // ---------------------------------------------------------------------------
  logic [WinW-1:0] short_win_q, long_win_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegLong) ? 32'(long_win_q) : 32'(short_win_q);

  function automatic logic [WinW-1:0] eff_win(input logic [WinW-1:0] w);
    logic [WinW-1:0] r;
    if (w == '0) begin
      r = WinW'(1);
    end else if (w > WinW'(MaxWindow)) begin
      r = WinW'(MaxWindow);
    end else begin
      r = w;
    end
    return r;
  endfunction

  logic [WinW-1:0] s_eff, l_eff, start_w;
  assign s_eff   = eff_win(short_win_q);
  assign l_eff   = eff_win(long_win_q);
  assign start_w = (s_eff > l_eff) ? s_eff : l_eff;

  // ---------------------------------------------------------------------------
  // Trace state
  // ---------------------------------------------------------------------------
  state_e             state_q;
  logic [PosW-1:0]    position_q;
  logic [SumW-1:0]    short_q, long_q, best_short_q, best_long_q;
  logic [PosW-1:0]    best_pos_q;
  logic               found_q, ovf_q;
  logic [SampleW-1:0] sample_q;
  logic               last_q;
  logic [SqW-1:0]     sq_q;
  logic [CntW-1:0]    mcnt_q;
  logic [2:0]         pidx_q;
  logic [ProdW-1:0]   prod_q;
  logic [AccW-1:0]    acc_a_q, acc_b_q;
  logic               out_valid_q;
  logic [OutW-1:0]    out_data_q;

  logic [PosW-1:0] p_w;
  logic            ovf_hit, first_w;
  assign p_w     = position_q + PosW'(1);
  assign ovf_hit = position_q >= PosW'(MaxTrace);
  assign first_w = (position_q == '0);   // first sample counts as zero

  // ---------------------------------------------------------------------------
  // Square history: reads old short-window then long-window entry, then writes
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [HistAw-1:0] ram_raddr;
  logic [SqW-1:0]    ram_rdata;

  assign ram_we    = (state_q == S_SUB_L);
  assign ram_raddr = (state_q == S_SQ) ? (p_w[HistAw-1:0] - s_eff[HistAw-1:0])
                                       : (p_w[HistAw-1:0] - l_eff[HistAw-1:0]);

  stalta_ram #(
    .Width (SqW),
    .Depth (MaxWindow)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (p_w[HistAw-1:0]),
    .wdata_i (sq_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier: sample square, then 8 half-word partial products of
  // short*best_long (acc_a) and best_short*long (acc_b)
  // ---------------------------------------------------------------------------
  logic [SampleW-1:0] mag;
  logic [SumW-1:0]    mx, my;
  logic [HalfW-1:0]   mul_a, mul_b;

  assign mag = sample_q[SampleW-1] ? (~sample_q + SampleW'(1)) : sample_q;
  assign mx  = mcnt_q[2] ? best_short_q : short_q;
  assign my  = mcnt_q[2] ? long_q : best_long_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        mul_a = first_w ? '0 : HalfW'(mag);
        mul_b = first_w ? '0 : HalfW'(mag);
      end
      S_MUL: begin
        mul_a = mcnt_q[0] ? HalfW'(mx[SumW-1:HalfW]) : mx[HalfW-1:0];
        mul_b = mcnt_q[1] ? HalfW'(my[SumW-1:HalfW]) : my[HalfW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // partial product placed at 0, 29 or 58 bits
  logic [AccW-1:0] part_w;
  always_comb begin
    case (2'(pidx_q[0]) + 2'(pidx_q[1]))
      2'd0:    part_w = AccW'(prod_q);
      2'd1:    part_w = AccW'(prod_q) << HalfW;
      default: part_w = AccW'(prod_q) << (2 * HalfW);
    endcase
  end

  logic qualify;
  assign qualify = !last_q && (position_q >= PosW'(start_w)) &&
                   (short_q != '0) && (long_q != '0);

  // centering offset, truncated toward zero
  logic signed [WinW:0]  diff_w;
  logic signed [WinW:0]  offset_w;
  logic signed [PickW-1:0] pick_w;
  assign diff_w   = $signed({1'b0, l_eff}) - $signed({1'b0, s_eff});
  assign offset_w = $signed(diff_w + (diff_w[WinW] ? (WinW+1)'(1) : '0)) >>> 1;
  assign pick_w   = $signed(PickW'(best_pos_q)) - PickW'(offset_w);

  logic out_free;
  logic fin_load;
  assign out_free = !out_valid_q || m_axis_tready;
  assign fin_load = (state_q == S_FIN) && last_q && out_free && !cfg_we;

  // input held off while a register write lands
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_we;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutBytesW'(out_data_q);

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      short_win_q  <= WinW'(WinShortDef);
      long_win_q   <= WinW'(WinLongDef);
      position_q   <= '0;
      short_q      <= '0;
      long_q       <= '0;
      best_short_q <= '0;
      best_long_q  <= SumW'(1);
      best_pos_q   <= PosW'(1);
      found_q      <= 1'b0;
      ovf_q        <= 1'b0;
      sample_q     <= '0;
      last_q       <= 1'b0;
      sq_q         <= '0;
      mcnt_q       <= '0;
      pidx_q       <= '0;
      acc_a_q      <= '0;
      acc_b_q      <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        // a window write restarts the trace
        if (paddr[2] == RegLong) begin
          long_win_q <= pwdata[WinW-1:0];
        end else begin
          short_win_q <= pwdata[WinW-1:0];
        end
        position_q   <= '0;
        short_q      <= '0;
        long_q       <= '0;
        best_short_q <= '0;
        best_long_q  <= SumW'(1);
        best_pos_q   <= PosW'(1);
        found_q      <= 1'b0;
        ovf_q        <= 1'b0;
      end else begin
        case (state_q)
          S_IDLE: begin
            if (s_axis_tvalid) begin
              sample_q <= s_axis_tdata[SampleW-1:0];
              last_q   <= s_axis_tlast;
              state_q  <= S_SQ;
            end
          end
          S_SQ: begin
            if (ovf_hit) begin
              ovf_q   <= 1'b1;
              state_q <= S_FIN;
            end else begin
              state_q <= S_SUB_S;
            end
          end
          S_SUB_S: begin
            sq_q    <= prod_q[SqW-1:0];
            short_q <= short_q - ((p_w > PosW'(s_eff)) ? SumW'(ram_rdata) : '0)
                       + SumW'(prod_q[SqW-1:0]);
            state_q <= S_SUB_L;
          end
          S_SUB_L: begin
            long_q     <= long_q - ((p_w > PosW'(l_eff)) ? SumW'(ram_rdata) : '0)
                          + SumW'(sq_q);
            position_q <= p_w;
            state_q    <= S_CHK;
          end
          S_CHK: begin
            acc_a_q <= '0;
            acc_b_q <= '0;
            mcnt_q  <= '0;
            if (!qualify) begin
              state_q <= S_FIN;
            end else if (!found_q) begin
              best_short_q <= short_q;
              best_long_q  <= long_q;
              best_pos_q   <= position_q;
              found_q      <= 1'b1;
              state_q      <= S_FIN;
            end else begin
              state_q <= S_MUL;
            end
          end
          S_MUL: begin
            // product of step k lands in the following cycle, tagged by pidx_q
            pidx_q <= mcnt_q[2:0];
            mcnt_q <= mcnt_q + CntW'(1);
            if (mcnt_q != '0) begin
              if (pidx_q[2]) begin
                acc_b_q <= acc_b_q + part_w;
              end else begin
                acc_a_q <= acc_a_q + part_w;
              end
            end
            if (mcnt_q == CntW'(NumPart)) begin
              state_q <= S_CMP;
            end
          end
          S_CMP: begin
            // strictly greater ratio wins; ties keep the earlier position
            if (acc_a_q > acc_b_q) begin
              best_short_q <= short_q;
              best_long_q  <= long_q;
              best_pos_q   <= position_q;
            end
            state_q <= S_FIN;
          end
          S_FIN: begin
            if (!last_q) begin
              state_q <= S_IDLE;
            end else if (out_free) begin
              out_data_q   <= {ovf_q, !found_q, pick_w};
              position_q   <= '0;
              short_q      <= '0;
              long_q       <= '0;
              best_short_q <= '0;
              best_long_q  <= SumW'(1);
              best_pos_q   <= PosW'(1);
              found_q      <= 1'b0;
              ovf_q        <= 1'b0;
              state_q      <= S_IDLE;
            end
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== src/stalta_chk.sv =====
module stalta_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [stalta_pkg::OutBytesW-1:0]     m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // a sample just taken holds the input off while the sequencer is busy with it
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("new sample taken too early");

  // a new result is only loaded from the final sequencer step, never from idle
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while idle");

endmodule

bind sta_lta_first_arrival_picker stalta_chk u_stalta_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import stalta_pkg::*;

  localparam int QuietLimit   = 5000;  // cycles without any handshake before giving up
  localparam int SettleCycles = 40;    // covers a full compare pass after the last request
  localparam int HoldCycles   = 400;   // long output hold-off to back up the input side
  localparam int RandItems    = 580;
  localparam int PressureAt   = 250;
  localparam int CalmAt       = 480;   // from here on neither side adds random gaps or stalls
  localparam int MaxReports   = 10;

  typedef struct packed {
    logic             too_long;
    logic             no_pick;
    logic [PickW-1:0] pick;
  } pick_t;

  typedef enum logic {RowSample, RowConfig} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        reg_sel;
    logic [31:0] value;
    logic        is_last;
    logic        typed;
    pick_t       exp;
  } row_t;

  // sample shapes for random traces
  typedef enum logic [2:0] {SigNoise, SigOnset, SigSparse, SigFlat, SigExtreme} sig_e;

  // defaults 10/30: offset 10, nothing qualifies -> 1 - 10
  localparam pick_t DefaultNoPick = '{too_long: 1'b0, no_pick: 1'b1, pick: PickW'(-9)};

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InBytesW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutBytesW-1:0] m_axis_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  sta_lta_first_arrival_picker i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Pick predictor: exact integer STA/LTA with its own copy of the windows
  // ---------------------------------------------------------------------------
  logic [WinW-1:0] win_short = WinW'(WinShortDef);
  logic [WinW-1:0] win_long  = WinW'(WinLongDef);
  int unsigned     trace_pos;
  logic [63:0]     sum_short, sum_long, best_short, best_long;
  int unsigned     best_pos;
  bit              found_any, overrun;
  logic [63:0]     energy_ring [MaxWindow];

  pick_t pending_picks [$];

  int unsigned mismatches, picks_checked, samples_sent, traces_sent, cfg_writes;

  bit calm_phase;
  bit hold_toggle;

  function automatic int unsigned clamp_window(logic [WinW-1:0] w);
    if (w == 0) return 1;
    if (w > MaxWindow) return MaxWindow;
    return int'(w);
  endfunction

  function automatic logic [63:0] square_mag(logic [SampleW-1:0] x);
    logic [SampleW-1:0] mag;
    mag = x[SampleW-1] ? (~x + 1'b1) : x;  // 0x800000 stays 2^23 as unsigned
    return 64'(mag) * 64'(mag);
  endfunction

  task automatic restart_trace();
    trace_pos  = 0;
    sum_short  = '0;
    sum_long   = '0;
    best_short = '0;
    best_long  = 64'd1;
    best_pos   = 1;
    found_any  = 1'b0;
    overrun    = 1'b0;
  endtask

  task automatic predict_pick(input logic [SampleW-1:0] smp, input logic is_last,
                              output bit emitted, output pick_t res);
    int unsigned ws, wl, first_pos, p;
    int          offset, pick;
    logic [63:0]  energy;
    logic [127:0] lhs, rhs;
    ws = clamp_window(win_short);
    wl = clamp_window(win_long);
    first_pos = (ws > wl) ? ws : wl;
    emitted = 1'b0;
    res = '0;
    if (trace_pos >= MaxTrace) begin
      overrun = 1'b1;
    end else begin
      p = trace_pos + 1;
      energy = (p == 1) ? 64'd0 : square_mag(smp);  // first sample counts as zero
      if (p > ws) sum_short -= energy_ring[(p - ws) % MaxWindow];
      if (p > wl) sum_long -= energy_ring[(p - wl) % MaxWindow];
      sum_short += energy;
      sum_long += energy;
      energy_ring[p % MaxWindow] = energy;
      trace_pos = p;
      if (!is_last && p >= first_pos && sum_short != 0 && sum_long != 0) begin
        // a/b > c/d  <=>  a*d > c*b, strict so ties keep the earlier position
        lhs = 128'(sum_short) * 128'(best_long);
        rhs = 128'(best_short) * 128'(sum_long);
        if (!found_any || lhs > rhs) begin
          best_short = sum_short;
          best_long  = sum_long;
          best_pos   = p;
          found_any  = 1'b1;
        end
      end
    end
    if (is_last) begin
      offset = (int'(wl) - int'(ws)) / 2;  // truncates toward zero, may be negative
      pick = int'(best_pos) - offset;
      res.pick = pick[PickW-1:0];
      res.no_pick = !found_any;
      res.too_long = overrun;
      emitted = 1'b1;
      restart_trace();
    end
  endtask

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: one request per call, random gaps unless in the calm phase
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [SampleW-1:0] smp, input logic is_last,
                             input bit typed, input pick_t typed_res);
    bit    emitted;
    pick_t res;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = InBytesW'(smp);
    s_axis_tlast  = is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pick(smp, is_last, emitted, res);
    if (emitted) pending_picks.push_back(typed ? typed_res : res);
    samples_sent++;
    if (is_last) traces_sent++;
    @(negedge clk_i);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
  endtask

  // wait until every pick is back and the sequencer has gone quiet
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending_picks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // APB write then read-back; the write also restarts the trace
  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_sel, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_sel == RegShort) win_short = value[WinW-1:0];
    else win_long = value[WinW-1:0];
    restart_trace();
    cfg_writes++;
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(value[WinW-1:0]))
      report_mismatch("register read-back", 32'(value[WinW-1:0]), prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [SampleW-1:0] draw_sample(sig_e shape, int unsigned idx,
                                                     int unsigned onset);
    logic [SampleW-1:0] v;
    case (shape)
      SigNoise: v = SampleW'($urandom);
      SigOnset: begin
        // quiet background, then a strong arrival
        if (idx < onset) v = SampleW'($urandom_range(0, 64) - 32);
        else v = SampleW'($urandom);
      end
      SigSparse: v = ($urandom_range(0, 7) == 0) ? SampleW'($urandom) : '0;
      SigFlat:   v = idx[0] ? SampleW'(1000) : SampleW'(-1000);  // equal ratios
      default: begin
        case ($urandom_range(0, 4))
          0:       v = {1'b1, {(SampleW-1){1'b0}}};
          1:       v = {1'b0, {(SampleW-1){1'b1}}};
          2:       v = '0;
          3:       v = SampleW'(1);
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic run_trace(input int unsigned len, input sig_e shape);
    int unsigned onset;
    onset = $urandom_range(1, len);
    for (int unsigned i = 1; i <= len; i++)
      send_sample(draw_sample(shape, i, onset), i == len, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  bit hold_seen;
  int unsigned hold_left, burst_left;
  bit burst_stall;

  always @(negedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (calm_phase) begin
      m_axis_tready = 1'b1;
    end else begin
      if (burst_left == 0) begin
        burst_stall = ($urandom_range(0, 2) == 0);
        burst_left = burst_stall ? $urandom_range(1, 13) : $urandom_range(1, 40);
      end
      m_axis_tready = !burst_stall;
      burst_left--;
    end
  end

  // compare each pick with the oldest expectation, field by field
  always @(posedge clk_i) begin
    pick_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pick_t'(m_axis_tdata[OutW-1:0]);
      picks_checked++;
      if (pending_picks.size() == 0) begin
        report_mismatch("pick with none outstanding", 0, got);
      end else begin
        want = pending_picks.pop_front();
        if (got.pick !== want.pick) report_mismatch("pick_index", want.pick, got.pick);
        if (got.no_pick !== want.no_pick) report_mismatch("no_pick", want.no_pick, got.no_pick);
        if (got.too_long !== want.too_long)
          report_mismatch("too_long", want.too_long, got.too_long);
      end
    end
  end

  // watchdog on handshake activity
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d picks outstanding",
               QuietLimit, pending_picks.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t        plan [$];
    int unsigned n, len, first_pos, rand_base;
    logic [31:0] s_val, l_val;
    bit          pressure_done;
    logic [31:0] big_short [3];
    logic [31:0] big_long [3];

    restart_trace();
    big_short = '{32'd0, 32'd2047, 32'd1024};
    big_long  = '{32'd2047, 32'd0, 32'd1};

    // defaults after reset: too short to qualify, result is fixed
    plan.push_back('{RowSample, 1'b0, 32'h7FFFFF, 1'b1, 1'b1, DefaultNoPick});
    plan.push_back('{RowSample, 1'b0, 32'h800000, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'h7FFFFF, 1'b1, 1'b1, DefaultNoPick});
    // short 2 / long 4: zero stretch, equal ratios, full-scale negative
    plan.push_back('{RowConfig, RegShort, 32'd2, 1'b0, 1'b0, '0});
    plan.push_back('{RowConfig, RegLong, 32'd4, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd5, 1'b0, 1'b0, '0});
    for (int i = 0; i < 4; i++) plan.push_back('{RowSample, 1'b0, 32'd0, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd100, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'hFFFF9C, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd1000, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'h800000, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd3, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd7, 1'b1, 1'b0, '0});
    // unfinished trace, then a register write that restarts it
    plan.push_back('{RowSample, 1'b0, 32'h7FFFFF, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'hFFFFFF, 1'b0, 1'b0, '0});
    // long window below short window: negative offset
    plan.push_back('{RowConfig, RegShort, 32'd5, 1'b0, 1'b0, '0});
    plan.push_back('{RowConfig, RegLong, 32'd3, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd9, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd1, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd2, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd3, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd50, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'hFFFFCE, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd50, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd50, 1'b0, 1'b0, '0});
    plan.push_back('{RowSample, 1'b0, 32'd1, 1'b1, 1'b0, '0});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowConfig) begin
        settle();
        cfg_write(plan[i].reg_sel, plan[i].value);
      end else begin
        send_sample(plan[i].value[SampleW-1:0], plan[i].is_last, plan[i].typed, plan[i].exp);
      end
    end

    // window extremes, including the out-of-range register values; short traces
    // still show the clamped windows through the centering offset
    for (int b = 0; b < 3; b++) begin
      settle();
      cfg_write(RegShort, big_short[b]);
      cfg_write(RegLong, big_long[b]);
      run_trace($urandom_range(2, 12), sig_e'($urandom_range(0, 4)));
      run_trace($urandom_range(1, 6), SigNoise);
    end

    // random phases with small windows
    rand_base = samples_sent;
    while (samples_sent - rand_base < RandItems) begin
      if (samples_sent - rand_base >= CalmAt) calm_phase = 1'b1;
      s_val = $urandom_range(1, 16);
      if ($urandom_range(0, 9) == 0) s_val = 0;
      if ($urandom_range(0, 4) == 0) l_val = $urandom_range(0, s_val);
      else l_val = s_val + $urandom_range(0, 24);
      settle();
      cfg_write(RegShort, s_val);
      cfg_write(RegLong, l_val);
      first_pos = clamp_window(s_val[WinW-1:0]);
      if (clamp_window(l_val[WinW-1:0]) > first_pos) first_pos = clamp_window(l_val[WinW-1:0]);
      if (!pressure_done && samples_sent - rand_base >= PressureAt) begin
        // hold the output off while short traces keep coming in
        hold_toggle = ~hold_toggle;
        repeat (24) run_trace($urandom_range(1, 3), SigNoise);
        pressure_done = 1'b1;
      end
      n = $urandom_range(3, 8);
      repeat (n) begin
        if (samples_sent - rand_base < RandItems) begin
          len = $urandom_range(1, first_pos + 24);
          run_trace(len, sig_e'($urandom_range(0, 4)));
        end
      end
    end

    s_axis_tvalid = 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d samples in %0d traces, %0d register writes, window extremes",
             samples_sent, traces_sent, cfg_writes);
    $display("and swapped windows under stalls; %0d picks checked, %0d mismatches",
             picks_checked, mismatches);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
